[sv/lccp_pkg.sv]
// Package with the types, constants and decoders of the coefficient compress and pack block.
package lccp_pkg;

    localparam int POLY_LENGTH = 256;
    localparam int IDX_W       = $clog2(POLY_LENGTH);
    localparam int COEF_W      = 13;
    localparam int MODE_W      = 3;
    localparam int PROD_W      = 45;
    localparam int CONST_W     = 32;
    localparam int VAL_W       = 11;
    localparam int ACC_W       = 18;

    typedef enum logic [MODE_W-1:0] {
        MODE_D1  = 3'd0,
        MODE_D4  = 3'd1,
        MODE_D5  = 3'd2,
        MODE_D10 = 3'd3,
        MODE_D11 = 3'd4
    } t_mode;

    typedef struct packed {
        logic [CONST_W-1:0] mult;
        logic [3:0]         width;
        logic [VAL_W-1:0]   mask;
        logic               short_shift;
    } t_mode_info;

    function automatic t_mode_info mode_info(input t_mode mode);
        t_mode_info info;
        unique case (mode)
            MODE_D1:  info = '{32'd2580335,    4'd1,  11'h001, 1'b0};
            MODE_D4:  info = '{32'd20642679,   4'd4,  11'h00f, 1'b0};
            MODE_D5:  info = '{32'd41285357,   4'd5,  11'h01f, 1'b0};
            MODE_D10: info = '{32'd1321131424, 4'd10, 11'h3ff, 1'b0};
            default:  info = '{32'd1290167,    4'd11, 11'h7ff, 1'b1};
        endcase
        return info;
    endfunction

endpackage

[sv/lattice_coeff_compress_pack_top.sv]
// Top level: compresses signed coefficients to D bits and packs them LSB-first into bytes.
// Pipeline: a taken coefficient is registered in the input stage, its product in the product
// stage and its bytes in the output buffer. Throughput: one coefficient per cycle while bytes
// are taken, except that one giving two bytes holds the packing stage until its first is taken.
// Reset (synchronous, active low) empties the pipeline, clears the bit accumulator and the
// coefficient counter, and selects the one-bit mode.
module lattice_coeff_compress_pack_top
    import lccp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,      // compress_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [12:0] coefficient, [15:13] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] packed_byte
    output logic        m_axis_tlast,    // last_of_run
    output logic        m_axis_tuser     // last_of_poly
);

    t_mode                     r_mode;
    logic                      r_s1_valid;
    logic signed [COEF_W-1:0]  r_s1_coef;
    logic                      r_s2_valid;
    logic signed [PROD_W-1:0]  r_s2_prod;
    logic [6:0]                r_bit_buf;
    logic [2:0]                r_bit_cnt;
    logic [IDX_W-1:0]          r_idx;
    logic [1:0]                r_ob_cnt;
    logic [7:0]                r_ob_b0;
    logic [7:0]                r_ob_b1;
    logic                      r_ob_poly;

    t_mode_info                w_info;
    logic signed [CONST_W-1:0] w_const;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_sum;
    logic [VAL_W-1:0]          w_v;
    logic [ACC_W-1:0]          w_acc;
    logic [ACC_W-1:0]          w_acc_sh;
    logic [4:0]                w_total;
    logic [1:0]                w_nbytes;
    logic                      w_last;
    logic                      w_ob_free;
    logic                      w_pack;
    logic                      w_s2_take;
    logic                      w_s1_take;
    logic                      w_out_fire;

    assign o_cfg_ready = 1'b1;

    assign w_info     = mode_info(r_mode);
    assign w_out_fire = m_axis_tvalid && m_axis_tready;
    assign w_ob_free  = (r_ob_cnt == 2'd0) || ((r_ob_cnt == 2'd1) && m_axis_tready);
    assign w_pack     = r_s2_valid && w_ob_free;
    assign w_s2_take  = !r_s2_valid || w_pack;
    assign w_s1_take  = r_s1_valid && w_s2_take;
    assign s_axis_tready = !r_s1_valid || w_s2_take;

    assign w_const = $signed(w_info.mult);
    assign w_prod  = r_s1_coef * w_const;

    always_comb begin
        if (w_info.short_shift) begin
            w_sum = r_s2_prod + PROD_W'(64'd1 << 20);
            w_v   = w_sum[31:21] & w_info.mask;
        end else begin
            w_sum = r_s2_prod + PROD_W'(64'd1 << 31);
            w_v   = w_sum[41:32] & w_info.mask;
        end
        w_acc    = ACC_W'(r_bit_buf) | (ACC_W'(w_v) << r_bit_cnt);
        w_total  = 5'(r_bit_cnt) + 5'(w_info.width);
        w_nbytes = w_total[4:3];
        w_acc_sh = w_acc >> {w_nbytes, 3'b000};
        w_last   = (r_idx == IDX_W'(POLY_LENGTH - 1));
    end

    assign m_axis_tvalid = (r_ob_cnt != 2'd0);
    assign m_axis_tdata  = r_ob_b0;
    assign m_axis_tlast  = (r_ob_cnt == 2'd1);
    assign m_axis_tuser  = (r_ob_cnt == 2'd1) && r_ob_poly;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_D1;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_bit_buf  <= '0;
            r_bit_cnt  <= '0;
            r_idx      <= '0;
            r_ob_cnt   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= t_mode'(i_cfg_data);
            end
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (w_s2_take) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_pack) begin
                if (w_last) begin
                    r_bit_buf <= '0;
                    r_bit_cnt <= '0;
                    r_idx     <= '0;
                end else begin
                    r_bit_buf <= w_acc_sh[6:0];
                    r_bit_cnt <= w_total[2:0];
                    r_idx     <= r_idx + 1'b1;
                end
                r_ob_cnt <= w_nbytes;
            end else if (w_out_fire) begin
                r_ob_cnt <= r_ob_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_coef <= $signed(s_axis_tdata[COEF_W-1:0]);
        end
        if (w_s1_take) begin
            r_s2_prod <= w_prod;
        end
        if (w_pack) begin
            r_ob_b0   <= w_acc[7:0];
            r_ob_b1   <= w_acc[15:8];
            r_ob_poly <= w_last;
        end else if (w_out_fire) begin
            r_ob_b0 <= r_ob_b1;
        end
    end

    // The last coefficient of a polynomial leaves an empty accumulator and a zero counter.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pack && w_last |=> (r_bit_cnt == 3'd0) && (r_idx == '0))
        else $error("accumulator not cleared at the end of a polynomial");

    // A two-byte result leaves exactly one byte pending after the first is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && (r_ob_cnt == 2'd2) |=> m_axis_tvalid && (r_ob_cnt == 2'd1))
        else $error("second byte of a request lost");

    // A product that cannot be packed is held.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !w_pack |=> r_s2_valid && $stable(r_s2_prod))
        else $error("stalled product overwritten");

    // The output buffer never claims more than two bytes.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt != 2'd3)
        else $error("output byte count out of range");

endmodule

[sim/tb.sv]
// Self-checking testbench for the coefficient compress and pack block.
module tb
    import lccp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       poly_last;
    } t_packed_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    logic [12:0]  pending_coeffs[$];
    t_packed_byte expected_bytes[$];
    bit           steady_flow = 1'b0;
    int           mismatches = 0;
    int           stall_cycles = 0;

    logic [2:0]   model_mode = MODE_D1;
    logic [6:0]   held_bits = '0;
    int           held_count = 0;
    int           poly_pos = 0;

    lattice_coeff_compress_pack_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic [10:0] compress_coeff(input logic [12:0] raw,
                                                   input logic [2:0] mode,
                                                   output int bits);
        longint     a;
        longint     c;
        logic [10:0] mask;
        logic [63:0] p;
        a = longint'($signed(raw));
        case (mode)
            MODE_D1: begin
                c = 2580335;    mask = 11'h001; bits = 1;
            end
            MODE_D4: begin
                c = 20642679;   mask = 11'h00f; bits = 4;
            end
            MODE_D5: begin
                c = 41285357;   mask = 11'h01f; bits = 5;
            end
            MODE_D10: begin
                c = 1321131424; mask = 11'h3ff; bits = 10;
            end
            default: begin
                bits = 11;
                p = a * 1290167 + 64'h100_0000_0000;
                p = (p >> 16) + 64'd16;
                return p[15:5];
            end
        endcase
        p = a * c + 64'h8000_0000 + 64'h1_0000_0000_0000;
        return p[42:32] & mask;
    endfunction

    task automatic pack_coeff(input logic [12:0] raw);
        logic [10:0]  value;
        int           bits;
        logic [17:0]  acc;
        int           total;
        bit           poly_end;
        t_packed_byte b;
        value = compress_coeff(raw, model_mode, bits);
        acc = 18'(held_bits) | (18'(value) << held_count);
        total = held_count + bits;
        poly_end = (poly_pos >= POLY_LENGTH - 1);
        while (total >= 8) begin
            total -= 8;
            b.data = acc[7:0];
            b.run_last = (total < 8);
            b.poly_last = (total < 8) && poly_end;
            expected_bytes.push_back(b);
            acc = acc >> 8;
        end
        if (poly_end) begin
            held_bits = '0;
            held_count = 0;
            poly_pos = 0;
        end else begin
            held_bits = acc[6:0];
            held_count = total;
            poly_pos++;
        end
    endtask

    function automatic logic [12:0] random_coeff();
        int x;
        if ($urandom_range(99) < 85) begin
            x = int'($urandom_range(6656)) - 3328;
        end else begin
            x = int'($urandom_range(8191));
        end
        return x[12:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pack_coeff(s_axis_tdata[12:0]);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_coeffs.size() != 0 && (steady_flow || $urandom_range(99) >= 32)) begin
                    s_axis_tdata <= {3'b000, pending_coeffs.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_packed_byte want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected byte, expected none, actual %02h/%b/%b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (want.data !== m_axis_tdata || want.run_last !== m_axis_tlast ||
                        want.poly_last !== m_axis_tuser) begin
                        $display("%0t: byte mismatch, expected %02h/%b/%b, actual %02h/%b/%b",
                                 $time, want.data, want.run_last, want.poly_last,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= steady_flow || $urandom_range(99) >= 32;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request taken for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic wait_drained();
        while (pending_coeffs.size() != 0 || s_axis_tvalid || expected_bytes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [2:0] mode);
        @(posedge i_clk);
        i_cfg_data <= mode;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_mode = mode;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic queue_directed();
        logic [12:0] edge_values[8];
        edge_values = '{13'h1000, 13'h12ff, 13'h1300, 13'h1fff,
                        13'h0000, 13'h0681, 13'h0d00, 13'h0fff};
        foreach (edge_values[k]) pending_coeffs.push_back(edge_values[k]);
    endtask

    initial begin
        logic [2:0] phase_modes[10];
        int         count;
        phase_modes = '{3'd4, 3'd0, 3'd7, 3'd1, 3'd2, 3'd5, 3'd3, 3'd6,
                        3'($urandom_range(7)), 3'($urandom_range(7))};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_directed();
        wait_drained();
        write_mode(MODE_D11);
        queue_directed();
        wait_drained();
        write_mode(MODE_D10);
        queue_directed();
        wait_drained();

        foreach (phase_modes[ph]) begin
            write_mode(phase_modes[ph]);
            steady_flow = (ph == 4);
            count = $urandom_range(30, 50);
            repeat (count) pending_coeffs.push_back(random_coeff());
            wait_drained();
        end
        steady_flow = 1'b0;

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/lccp_pkg.sv
sv/lattice_coeff_compress_pack_top.sv
sim/tb.sv
